### sv/rwh_pkg.sv
// Shared package for the rolling window hash block.
// Holds field widths, register indexes and reset values, and the request and
// response types of the modular multiply unit. No dependencies.
`default_nettype none

package rwh_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int LINE_BITS_DEF  = 16;

  localparam int WORD_W    = 31;
  localparam int CH_W      = 8;
  localparam int LINE_W    = 16;
  localparam int LEN_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int BIT_W     = $clog2(WORD_W);

  // Index of the most significant multiplier bit for a full word and a byte.
  localparam logic [BIT_W-1:0] TOP_WORD = BIT_W'(WORD_W - 1);
  localparam logic [BIT_W-1:0] TOP_BYTE = BIT_W'(CH_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_WEIGHT = 2'd3;

  localparam logic [WORD_W-1:0] MODULUS_RST    = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] BASE_RST       = 31'd256;
  localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = 7'd8;
  localparam logic [WORD_W-1:0] TOP_WEIGHT_RST = 31'd1;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [BIT_W-1:0]  top;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } mm_rsp_t;

endpackage

`default_nettype wire

### sv/rolling_window_hash_with_lines.sv
// Rolling Rabin-Karp hash over the last k bytes, with first and last line numbers.
// An item reduces its byte, removes the outgoing byte's weight once the window is
// full, then multiplies by base and adds the byte; a result follows once k bytes are in.
// The first item after reset or a register write also reduces top_weight first.
// The block takes one item at a time, paced by the serial multiplier (one bit per cycle).
// Reset is synchronous: registers return to their reset values and the window empties.
`default_nettype none

module rolling_window_hash_with_lines #(
  parameter int MAX_WINDOW = rwh_pkg::MAX_WINDOW_DEF,
  parameter int LINE_BITS  = rwh_pkg::LINE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rwh_pkg::CH_W-1:0]        ch,
  input  logic [rwh_pkg::LINE_W-1:0]      line,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rwh_pkg::WORD_W-1:0]      hash,
  output logic [rwh_pkg::LINE_W-1:0]      start_line,
  output logic [rwh_pkg::LINE_W-1:0]      end_line,
  input  logic                            cfg_we,
  input  logic [rwh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwh_pkg::WORD_W-1:0]      cfg_data
);
  import rwh_pkg::*;

  localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SW    = CW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_TW   = 3'd2;
  localparam logic [2:0] S_CH   = 3'd3;
  localparam logic [2:0] S_DROP = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]           state;
  logic [WORD_W-1:0]    modulus;
  logic [WORD_W-1:0]    base;
  logic [LEN_W-1:0]     window_len;
  logic [WORD_W-1:0]    top_weight;
  logic                 stale;
  logic [WORD_W-1:0]    tw_red;
  logic [PW-1:0]        wp;
  logic [CNT_W-1:0]     fill;
  logic [WORD_W-1:0]    run_hash;
  logic [CH_W-1:0]      ch_r;
  logic [LINE_BITS-1:0] line_r;
  logic [WORD_W-1:0]    ch_red;

  logic [CW-1:0]        k_eff;
  logic [CW-1:0]        wl_ext;
  logic                 full;
  logic                 emits;
  logic [SW-1:0]        old_sum;
  logic [SW-1:0]        old_wrap;
  logic [PW-1:0]        old_idx;
  logic [PW-1:0]        first_idx;
  logic [PW-1:0]        wp_inc;
  logic [WORD_W:0]      d_sub;
  logic [WORD_W:0]      d_addq;
  logic [WORD_W-1:0]    diff;
  logic [WORD_W:0]      fin_sum;
  logic [WORD_W-1:0]    fin;

  logic [CH_W-1:0]      byte_rd;
  logic [LINE_BITS-1:0] line_rd;
  logic                 ram_re;
  logic                 ram_we;

  mm_req_t              req;
  mm_rsp_t              rsp;

  assign in_ready = (state == S_IDLE);

  // Window length zero acts as one; lengths beyond the ring saturate.
  always_comb begin
    wl_ext = CW'(window_len);
    if (wl_ext == '0) begin
      k_eff = CW'(1);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      k_eff = CW'(MAX_WINDOW);
    end else begin
      k_eff = wl_ext;
    end
  end

  assign full  = (CW'(fill) >= k_eff);
  assign emits = full || (CW'(fill + CNT_W'(1)) == k_eff);

  // The outgoing byte sits k entries behind the write pointer; the window's
  // first byte is the entry just after it.
  always_comb begin
    old_sum   = SW'(wp) + SW'(MAX_WINDOW) - SW'(k_eff);
    old_wrap  = (old_sum >= SW'(MAX_WINDOW)) ? old_sum - SW'(MAX_WINDOW) : old_sum;
    old_idx   = old_wrap[PW-1:0];
    first_idx = (old_idx == PW'(MAX_WINDOW - 1)) ? '0 : old_idx + PW'(1);
    wp_inc    = (wp == PW'(MAX_WINDOW - 1)) ? '0 : wp + PW'(1);
  end

  always_comb begin
    d_sub   = {1'b0, run_hash} - {1'b0, rsp.result};
    d_addq  = {1'b0, run_hash} + {1'b0, modulus} - {1'b0, rsp.result};
    diff    = d_sub[WORD_W] ? d_addq[WORD_W-1:0] : d_sub[WORD_W-1:0];
    fin_sum = {1'b0, rsp.result} + {1'b0, ch_red};
    fin     = (fin_sum >= {1'b0, modulus}) ? WORD_W'(fin_sum - {1'b0, modulus})
                                             : fin_sum[WORD_W-1:0];
  end

  // Multiplier operand selection for each phase of an item.
  always_comb begin
    req.start = 1'b0;
    req.x     = WORD_W'(1);
    req.y     = WORD_W'(ch_r);
    req.top   = TOP_BYTE;
    case (state)
      S_RD: begin
        req.start = 1'b1;
        if (stale) begin
          req.y   = top_weight;
          req.top = TOP_WORD;
        end
      end
      S_TW: begin
        req.start = rsp.done;
      end
      S_CH: begin
        req.start = rsp.done;
        if (full) begin
          req.x = tw_red;
          req.y = WORD_W'(byte_rd);
        end else begin
          req.x   = run_hash;
          req.y   = base;
          req.top = TOP_WORD;
        end
      end
      S_DROP: begin
        req.start = rsp.done;
        req.x     = diff;
        req.y     = base;
        req.top   = TOP_WORD;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  assign ram_re = (state == S_RD);
  assign ram_we = (state == S_MUL) && rsp.done;

  rwh_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .q   (modulus),
    .req (req),
    .rsp (rsp)
  );

  rwh_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_WINDOW)
  ) u_byte_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ch_r),
    .re    (ram_re),
    .raddr (old_idx),
    .rdata (byte_rd)
  );

  rwh_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (line_r),
    .re    (ram_re),
    .raddr (first_idx),
    .rdata (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      modulus    <= MODULUS_RST;
      base       <= BASE_RST;
      window_len <= WINDOW_LEN_RST;
      top_weight <= TOP_WEIGHT_RST;
      stale      <= 1'b1;
      wp         <= '0;
      fill       <= '0;
      run_hash   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_OUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              wp       <= '0;
              fill     <= '0;
              run_hash <= '0;
            end
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= stale ? S_TW : S_CH;
        end
        S_TW: begin
          if (rsp.done) begin
            stale <= 1'b0;
            state <= S_CH;
          end
        end
        S_CH: begin
          if (rsp.done) begin
            state <= full ? S_DROP : S_MUL;
          end
        end
        S_DROP: begin
          if (rsp.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (rsp.done) begin
            run_hash <= fin;
            wp       <= wp_inc;
            if (!full) begin
              fill <= fill + CNT_W'(1);
            end
            state <= emits ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Any register write empties the window and forces a new top_weight reduction.
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:    modulus    <= cfg_data;
          REG_BASE:       base       <= cfg_data;
          REG_WINDOW_LEN: window_len <= cfg_data[LEN_W-1:0];
          REG_TOP_WEIGHT: top_weight <= cfg_data;
          default:        modulus    <= modulus;
        endcase
        wp       <= '0;
        fill     <= '0;
        run_hash <= '0;
        stale    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_valid) begin
      ch_r   <= ch;
      line_r <= LINE_BITS'(line);
    end
    if ((state == S_TW) && rsp.done) begin
      tw_red <= rsp.result;
    end
    if ((state == S_CH) && rsp.done) begin
      ch_red <= rsp.result;
    end
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      hash     <= run_hash;
      // A one-byte window starts at the byte just written, which the ring
      // read could not yet see.
      start_line <= (k_eff == CW'(1)) ? LINE_W'(line_r) : LINE_W'(line_rd);
      end_line   <= LINE_W'(line_r);
    end
  end

endmodule

`default_nettype wire

### sv/rwh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rwh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/rwh_modmul.sv
// Bit-serial modular multiplier: result = x * y mod q, one multiplier bit per
// cycle, most significant first. Requires x < q; y may be any word.
// Depends on rwh_pkg.
`default_nettype none

module rwh_modmul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rwh_pkg::WORD_W-1:0]   q,
  input  rwh_pkg::mm_req_t             req,
  output rwh_pkg::mm_rsp_t             rsp
);
  import rwh_pkg::*;

  logic              running;
  logic              done;
  logic [BIT_W-1:0]  cnt;
  logic [WORD_W-1:0] x_r;
  logic [WORD_W-1:0] y_r;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] acc_next;

  logic [WORD_W+1:0] s;
  logic [WORD_W+1:0] q1;
  logic [WORD_W+1:0] q2;
  logic              zq;

  // With acc < q and x < q the partial sum stays below 3q, so subtracting
  // q or 2q, chosen by two parallel compares, brings it back below q.
  always_comb begin
    q1 = {2'b00, q};
    q2 = {1'b0, q, 1'b0};
    zq = (q < WORD_W'(2));
    s  = {1'b0, acc, 1'b0} + (y_r[cnt] ? {2'b00, x_r} : '0);
    if (zq) begin
      acc_next = '0;
    end else if (s >= q2) begin
      acc_next = WORD_W'(s - q2);
    end else if (s >= q1) begin
      acc_next = WORD_W'(s - q1);
    end else begin
      acc_next = WORD_W'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= req.top;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= req.x;
      y_r <= req.y;
      acc <= '0;
    end else if (running) begin
      acc <= acc_next;
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

`default_nettype wire

### sv/rwh_check.sv
// Port-level checker for the rolling window hash block, bound to the top level.
// Depends on rwh_pkg and rolling_window_hash_with_lines.
`default_nettype none

module rwh_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rwh_pkg::WORD_W-1:0]  hash,
  input logic [rwh_pkg::LINE_W-1:0]  start_line,
  input logic [rwh_pkg::LINE_W-1:0]  end_line
);
  import rwh_pkg::*;

  // A result that waits must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash) && $stable(start_line)
                                && $stable(end_line))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item finished");

  // A new result only appears at the end of an item's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // The hash is reduced below a 31-bit modulus, so it never reaches all ones.
  a_hash_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hash != {WORD_W{1'b1}})
    else $error("hash not reduced");

endmodule

bind rolling_window_hash_with_lines rwh_check u_rwh_check (.*);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for rolling_window_hash_with_lines: drives text bytes with
// random gaps, predicts each window hash and line pair, and checks every result item.
// Depends on rwh_pkg and the rolling_window_hash_with_lines RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rwh_pkg::*;

  localparam int RING      = MAX_WINDOW_DEF;
  localparam int SETTLE    = 120;
  localparam int STALL_MAX = 3000;

  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [LINE_W-1:0] line;
    logic              restart;
  } text_byte_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash;
    logic [LINE_W-1:0] start_line;
    logic [LINE_W-1:0] end_line;
  } window_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      ch        = '0;
  logic [LINE_W-1:0]    line      = '0;
  logic                 restart   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    hash;
  logic [LINE_W-1:0]    start_line;
  logic [LINE_W-1:0]    end_line;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  // Predicted block state and register copies.
  logic [WORD_W-1:0] modulus_reg = MODULUS_RST;
  logic [WORD_W-1:0] base_reg    = BASE_RST;
  logic [LEN_W-1:0]  len_reg     = WINDOW_LEN_RST;
  logic [WORD_W-1:0] weight_reg  = TOP_WEIGHT_RST;
  logic [CH_W-1:0]   ring_ch   [RING];
  logic [LINE_W-1:0] ring_line [RING];
  int unsigned       head      = 0;
  int unsigned       fill      = 0;
  logic [WORD_W-1:0] acc_hash  = '0;

  text_byte_t  bytes_q[$];
  window_t     window_hashes_q[$];
  text_byte_t  nxt;
  window_t     want;
  logic [LINE_W-1:0] line_no = '0;
  bit          steady = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet  = 0;

  rolling_window_hash_with_lines u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .line       (line),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash       (hash),
    .start_line (start_line),
    .end_line   (end_line),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [WORD_W-1:0] mod_q(input logic [63:0] v, input logic [WORD_W-1:0] q);
    if (q < 2) return '0;
    return WORD_W'(v % 64'(q));
  endfunction

  function automatic logic [WORD_W-1:0] pow_mod(input logic [WORD_W-1:0] b,
                                                input int unsigned e,
                                                input logic [WORD_W-1:0] q);
    logic [WORD_W-1:0] r;
    r = mod_q(64'd1, q);
    repeat (e) r = mod_q(64'(r) * 64'(mod_q(64'(b), q)), q);
    return r;
  endfunction

  // Takes one byte into the predicted window and queues the window it yields, if any.
  task automatic roll_window(input text_byte_t tb);
    logic [WORD_W-1:0] q, b, h, tw, drop, diff;
    int unsigned       k, oldest;
    window_t           w;
    q = modulus_reg;
    k = (len_reg == 0) ? 1 : ((len_reg > RING) ? RING : len_reg);
    b = mod_q(64'(base_reg), q);
    h = mod_q(64'(acc_hash), q);
    if (tb.restart) begin
      head = 0;
      fill = 0;
      acc_hash = '0;
      h = '0;
    end
    if (fill >= k) begin
      // Remove the outgoing byte's weight before shifting the new byte in.
      oldest = (head + RING - k) % RING;
      tw = mod_q(64'(weight_reg), q);
      drop = mod_q(64'(ring_ch[oldest]) * 64'(tw), q);
      diff = mod_q(64'(h) + 64'(q) - 64'(drop), q);
      h = mod_q(64'(diff) * 64'(b) + 64'(tb.ch), q);
      fill = k;
    end else begin
      h = mod_q(64'(h) * 64'(b) + 64'(tb.ch), q);
      fill++;
    end
    ring_ch[head] = tb.ch;
    ring_line[head] = tb.line;
    head = (head + 1) % RING;
    acc_hash = h;
    if (fill >= k) begin
      w.hash = h;
      w.start_line = ring_line[(head + RING - k) % RING];
      w.end_line = tb.line;
      window_hashes_q = {window_hashes_q, w};
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MODULUS:    modulus_reg = val;
      REG_BASE:       base_reg = val;
      REG_WINDOW_LEN: len_reg = val[LEN_W-1:0];
      REG_TOP_WEIGHT: weight_reg = val;
      default: ;
    endcase
    // Any register write empties the window.
    head = 0;
    fill = 0;
    acc_hash = '0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [WORD_W-1:0] q, input logic [WORD_W-1:0] b,
                           input logic [LEN_W-1:0] k, input logic [WORD_W-1:0] tw);
    write_reg(REG_MODULUS, q);
    write_reg(REG_BASE, b);
    write_reg(REG_WINDOW_LEN, WORD_W'(k));
    write_reg(REG_TOP_WEIGHT, tw);
  endtask

  task automatic push_byte(input logic [CH_W-1:0] c, input logic [LINE_W-1:0] ln,
                           input logic rs);
    text_byte_t item;
    item.ch = c;
    item.line = ln;
    item.restart = rs;
    bytes_q = {bytes_q, item};
  endtask

  // Mostly running text with slowly rising line numbers; some restarts and line jumps.
  task automatic feed_text(input int unsigned n, input int unsigned restart_pct);
    logic rs;
    repeat (n) begin
      rs = ($urandom_range(99) < restart_pct);
      if (rs || $urandom_range(99) < 5) line_no = LINE_W'($urandom);
      else if ($urandom_range(7) == 0) line_no = line_no + 1'b1;
      push_byte(CH_W'($urandom), line_no, rs);
    end
  endtask

  // Waits until every item is taken and every window has come out, then lets
  // the block finish any byte that yields no window.
  task automatic drain_text();
    while (bytes_q.size() != 0 || in_valid || window_hashes_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) roll_window({ch, line, restart});
      if (!in_valid || in_ready) begin
        if (bytes_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          nxt = bytes_q.pop_front();
          in_valid <= 1'b1;
          ch <= nxt.ch;
          line <= nxt.line;
          restart <= nxt.restart;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      out_ready <= steady || ($urandom_range(99) >= 9);
      if (out_valid && out_ready) begin
        if (window_hashes_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected window: hash=%0d lines %0d..%0d", hash, start_line, end_line);
        end else begin
          want = window_hashes_q.pop_front();
          if (hash !== want.hash || start_line !== want.start_line ||
              end_line !== want.end_line) begin
            errors++;
            if (errors <= 10)
              $display("window mismatch: expected hash=%0d lines %0d..%0d, got %0d lines %0d..%0d",
                       want.hash, want.start_line, want.end_line, hash, start_line, end_line);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [WORD_W-1:0] q, b, tw;
    logic [LEN_W-1:0]  k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: fill the window with extreme bytes and lines, slide it,
    // then restart in the middle of a full window.
    push_byte(8'hFF, 16'hFFFF, 1'b1);
    for (int i = 0; i < 7; i++) push_byte(8'hFF, LINE_W'(i), 1'b0);
    push_byte(8'h00, 16'hFFFF, 1'b0);
    push_byte(8'h80, 16'h8000, 1'b0);
    push_byte(8'h01, 16'h7FFF, 1'b0);
    push_byte(8'h5A, 16'd100, 1'b1);
    push_byte(8'hA5, 16'd101, 1'b0);
    drain_text();

    // Largest modulus, base and window.
    configure(31'h7FFF_FFFF, 31'h7FFF_FFFE, 7'd64, pow_mod(31'h7FFF_FFFE, 63, 31'h7FFF_FFFF));
    feed_text(100, 1);
    drain_text();
    // Smallest modulus, base and window.
    configure(31'd2, 31'd2, 7'd1, 31'd1);
    feed_text(30, 5);
    drain_text();
    // Modulus zero and window length zero.
    configure(31'd0, WORD_W'($urandom), 7'd0, WORD_W'($urandom));
    feed_text(25, 5);
    drain_text();
    // Modulus one.
    configure(31'd1, 31'd256, 7'd3, 31'd1);
    feed_text(25, 5);
    drain_text();
    // Base and top weight above the modulus; window length saturates.
    configure(31'd1000003, 31'h7FFF_FFFE, 7'h7F, 31'h7FFF_FFFE);
    feed_text(90, 1);

    for (int p = 0; p < 7; p++) begin
      drain_text();
      if ($urandom_range(1)) q = WORD_W'($urandom) | 31'h4000_0000;
      else q = WORD_W'($urandom_range(1000, 2));
      b = ($urandom_range(3) == 0) ? WORD_W'($urandom) : WORD_W'($urandom % q);
      k = ($urandom_range(3) == 0) ? LEN_W'($urandom_range(64, 1))
                                   : LEN_W'($urandom_range(12, 1));
      tw = ($urandom_range(3) == 0) ? WORD_W'($urandom) : pow_mod(b, k - 1, q);
      steady = (p == 0);
      configure(q, b, k, tw);
      if (p == 1) begin
        // Let every window come out mid-text before sending more.
        feed_text(27, 4);
        drain_text();
        feed_text(28, 4);
      end else begin
        feed_text(55, 4);
      end
    end

    drain_text();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
